/* hdl/ptt_pkg.sv */
// Shared types, codes and helpers for the periodic timer table.
package ptt_pkg;

  localparam int TABLE_DEPTH_DEF   = 16;
  localparam int MS_PER_SECOND_DEF = 1000;
  localparam int MAX_RESULTS       = 16;
  localparam logic [15:0] CHECK_PERIOD_RST = 16'd1000;

  // Register index carried by paddr[2]
  localparam logic REG_CHECK_PERIOD = 1'b0;

  typedef enum logic [2:0] {
    K_TICK         = 3'd0,
    K_PUSH_REL     = 3'd1,
    K_PUSH_ABS     = 3'd2,
    K_CANCEL_ID    = 3'd3,
    K_CANCEL_OWNER = 3'd4,
    K_SET_INTERVAL = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_FIRED        = 3'd0,
    ST_PUSHED       = 3'd1,
    ST_FULL         = 3'd2,
    ST_CANCELLED    = 3'd3,
    ST_NOT_FOUND    = 3'd4,
    ST_INTERVAL_SET = 3'd5,
    ST_OWNER_NULL   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_PEND, S_SEL, S_FIRE, S_EMIT, S_RESP
  } state_t;

  typedef struct packed {
    logic [47:0] deadline;
    logic [31:0] interval;
    logic        rpt;
    logic [15:0] owner;
    logic [7:0]  method;
    logic [15:0] id;
  } entry_t;

  // now plus interval, saturating at 48 bits
  function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[48] ? {48{1'b1}} : s[47:0];
  endfunction

endpackage

/* hdl/ptt_if.sv */
// Command and response channel interfaces of the periodic timer table.
interface ptt_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] owner;
  logic [7:0]  method;
  logic        match_method;
  logic [31:0] interval_ms;
  logic        repeat_req;
  logic [31:0] schedule_s;
  logic [15:0] timer_id;

  modport source (output valid, kind, owner, method, match_method, interval_ms,
                  repeat_req, schedule_s, timer_id, input ready);
  modport sink   (input valid, kind, owner, method, match_method, interval_ms,
                  repeat_req, schedule_s, timer_id, output ready);
endinterface

interface ptt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] result_id;
  logic [15:0] result_owner;
  logic [7:0]  result_method;
  logic        last;

  modport source (output valid, status, result_id, result_owner, result_method, last,
                  input ready);
  modport sink   (input valid, status, result_id, result_owner, result_method, last,
                  output ready);
endinterface

/* hdl/periodic_timer_table.sv */
// Top level of the periodic timer table: timer store, scan sequencer, APB register.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+---------------------------------------------
//   cmd     | in  | valid/ready       | kind owner method match_method interval_ms
//           |     |                   | repeat_req schedule_s timer_id
//   rsp     | out | valid/ready       | status result_id result_owner result_method last
//   apb     | in  | psel/penable      | check_period_ms at byte 0
//
// Push, cancel-by-id, set-interval and nonzero-owner cancel commands make one pass
// through the entry memory, whose single read port visits one slot a cycle. A tick
// that runs a check makes one pass to mark due timers, then a selection pass per fired timer.
// Reset (rst, synchronous) clears valid bits and counters; no clearing pass.
// The next command is taken while a response waits in the output register; a
// stalled rsp holds the check sequence until the transfer completes.
module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
  parameter int MS_PER_SECOND = MS_PER_SECOND_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ptt_cmd_if.sink     cmd,
  ptt_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int FW = $clog2(MAX_RESULTS + 1);

  state_t state, state_next;

  // Control and counters
  logic [15:0] period, countdown, next_id;
  logic [47:0] now_ms;
  logic [CW-1:0] seq, seq_m1, scan_idx, pend_cnt;
  logic [FW-1:0] fire_cnt;
  logic [TABLE_DEPTH-1:0] valid, pending;
  logic [IW-1:0] order [TABLE_DEPTH];

  // Latched command
  kind_t       req_kind;
  logic [15:0] req_owner, req_tid;
  logic [7:0]  req_method;
  logic        req_mm, req_repeat;
  logic [31:0] req_interval, req_sched;
  logic [47:0] op_deadline;
  logic        found;
  logic [15:0] push_id;

  // Scan pipeline
  logic          issuing, scanning, scan_end, d_vld;
  logic [IW-1:0] rd_addr, d_idx;
  entry_t        mem [TABLE_DEPTH];
  entry_t        rdata;

  // Best candidate during selection
  logic          best_vld;
  logic [IW-1:0] best_idx, best_ord;
  entry_t        best_ent;
  logic          fire_last;

  // Strobes
  logic          mem_we, ord_rm, ord_nw, ord_push, hit, out_load, better;
  logic [IW-1:0] mem_waddr, ord_idx, r_ord;
  entry_t        mem_wdata;
  logic          dv;

  // Output register
  logic        o_valid, o_last;
  status_t     o_status, resp_status;
  logic [15:0] o_id, o_owner;
  logic [7:0]  o_method;

  // APB register
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_CHECK_PERIOD);
  assign prdata = (paddr[2] == REG_CHECK_PERIOD) ? {16'b0, period} : 32'b0;

  assign cmd.ready         = (state == S_IDLE);
  assign rsp.valid         = o_valid;
  assign rsp.status        = o_status;
  assign rsp.result_id     = o_id;
  assign rsp.result_owner  = o_owner;
  assign rsp.result_method = o_method;
  assign rsp.last          = o_last;

  assign seq_m1   = seq - CW'(1);
  assign scanning = (state inside {S_SCAN, S_PEND, S_SEL});
  assign issuing  = scanning && (scan_idx < CW'(TABLE_DEPTH));
  assign rd_addr  = scan_idx[IW-1:0];
  assign scan_end = scanning && !issuing && !d_vld;
  assign dv       = valid[d_idx];
  assign r_ord    = order[ord_idx];

  assign better = !best_vld || (rdata.deadline < best_ent.deadline) ||
                  ((rdata.deadline == best_ent.deadline) && (r_ord > best_ord));

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[rd_addr];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      S_IDLE: if (cmd.valid) state_next = S_EXEC;
      S_EXEC: begin
        case (req_kind)
          K_TICK:         state_next = (countdown <= 16'd1) ? S_PEND : S_IDLE;
          K_PUSH_REL, K_PUSH_ABS, K_CANCEL_ID, K_SET_INTERVAL: state_next = S_SCAN;
          K_CANCEL_OWNER: state_next = (req_owner == 16'd0) ? S_RESP : S_SCAN;
          default:        state_next = S_IDLE;
        endcase
      end
      S_SCAN: if (scan_end) state_next = S_RESP;
      S_PEND: if (scan_end) state_next = (pend_cnt == '0) ? S_IDLE : S_SEL;
      S_SEL:  if (scan_end) state_next = S_FIRE;
      S_FIRE: state_next = S_EMIT;
      S_EMIT: begin
        if (!o_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = fire_last ? S_IDLE : S_SEL;
        end
      end
      S_RESP: begin
        if (!o_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Per-slot actions and fire updates
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = d_idx;
    mem_wdata = rdata;
    ord_rm    = 1'b0;
    ord_nw    = 1'b0;
    ord_push  = 1'b0;
    ord_idx   = d_idx;
    hit       = 1'b0;
    if (state == S_SCAN && d_vld) begin
      case (req_kind)
        K_PUSH_REL, K_PUSH_ABS: begin
          if (!found && !dv) begin
            hit                = 1'b1;
            ord_push           = 1'b1;
            mem_we             = 1'b1;
            mem_wdata.deadline = op_deadline;
            mem_wdata.interval = (req_kind == K_PUSH_REL) ? req_interval : 32'd0;
            mem_wdata.rpt      = (req_kind == K_PUSH_REL) ? req_repeat : 1'b0;
            mem_wdata.owner    = req_owner;
            mem_wdata.method   = req_method;
            mem_wdata.id       = next_id;
          end
        end
        K_CANCEL_ID: begin
          if (!found && dv && rdata.id == req_tid) begin
            hit    = 1'b1;
            ord_rm = 1'b1;
          end
        end
        K_CANCEL_OWNER: begin
          if (dv && rdata.owner == req_owner && (!req_mm || rdata.method == req_method)) begin
            hit    = 1'b1;
            ord_rm = 1'b1;
          end
        end
        K_SET_INTERVAL: begin
          if (!found && dv && rdata.id == req_tid) begin
            hit                = 1'b1;
            mem_we             = 1'b1;
            mem_wdata.interval = req_interval;
            mem_wdata.deadline = op_deadline;
            ord_nw             = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (state == S_FIRE) begin
      ord_idx   = best_idx;
      mem_waddr = best_idx;
      if (best_ent.rpt) begin
        mem_we             = 1'b1;
        mem_wdata          = best_ent;
        mem_wdata.deadline = sat_add(now_ms, best_ent.interval);
        ord_nw             = 1'b1;
      end else begin
        ord_rm = 1'b1;
      end
    end
  end

  // Response status for single-result commands
  always_comb begin
    case (req_kind)
      K_PUSH_REL, K_PUSH_ABS: resp_status = found ? ST_PUSHED : ST_FULL;
      K_CANCEL_ID:    resp_status = found ? ST_CANCELLED : ST_NOT_FOUND;
      K_CANCEL_OWNER: resp_status = (req_owner == 16'd0) ? ST_OWNER_NULL :
                                    (found ? ST_CANCELLED : ST_NOT_FOUND);
      K_SET_INTERVAL: resp_status = found ? ST_INTERVAL_SET : ST_NOT_FOUND;
      default:        resp_status = ST_NOT_FOUND;
    endcase
  end

  // Valid bits, live count, ids
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      seq     <= '0;
      next_id <= '0;
    end else begin
      if (ord_rm) begin
        valid[ord_idx] <= 1'b0;
        seq            <= seq_m1;
      end
      if (ord_push) begin
        valid[ord_idx] <= 1'b1;
        seq            <= seq + CW'(1);
        next_id        <= next_id + 16'd1;
      end
    end
  end

  // Age ranks: removal and re-arm close the gap above the entry
  always_ff @(posedge clk) begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      if ((ord_rm || ord_nw) && valid[j] && order[j] > r_ord && IW'(j) != ord_idx)
        order[j] <= order[j] - IW'(1);
    end
    if (ord_nw)   order[ord_idx] <= seq_m1[IW-1:0];
    if (ord_push) order[ord_idx] <= seq[IW-1:0];
  end

  // Clock, countdown and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms    <= '0;
      countdown <= CHECK_PERIOD_RST;
      period    <= CHECK_PERIOD_RST;
    end else begin
      if (state == S_EXEC && req_kind == K_TICK) begin
        now_ms    <= now_ms + 48'd1;
        countdown <= (countdown <= 16'd1) ? period : countdown - 16'd1;
      end
      if (cfg_we && pwdata[15:0] != 16'd0) begin
        period    <= pwdata[15:0];
        countdown <= pwdata[15:0];
      end
    end
  end

  // Command capture and scan sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld    <= 1'b0;
      scan_idx <= '0;
      found    <= 1'b0;
      best_vld <= 1'b0;
      pend_cnt <= '0;
      fire_cnt <= '0;
    end else begin
      d_vld <= issuing;
      d_idx <= rd_addr;
      if (issuing) scan_idx <= scan_idx + CW'(1);

      if (cmd.valid && cmd.ready) begin
        req_kind     <= kind_t'(cmd.kind);
        req_owner    <= cmd.owner;
        req_method   <= cmd.method;
        req_mm       <= cmd.match_method;
        req_interval <= cmd.interval_ms;
        req_repeat   <= cmd.repeat_req;
        req_sched    <= cmd.schedule_s;
        req_tid      <= cmd.timer_id;
      end

      if (state == S_EXEC) begin
        scan_idx <= '0;
        found    <= 1'b0;
        pend_cnt <= '0;
        fire_cnt <= '0;
        best_vld <= 1'b0;
        if (req_kind == K_PUSH_ABS) op_deadline <= 48'(req_sched) * 48'(MS_PER_SECOND);
        else                        op_deadline <= sat_add(now_ms, req_interval);
      end

      if (hit) begin
        found <= 1'b1;
        if (ord_push) push_id <= next_id;
      end

      // Pending snapshot at check time
      if (state == S_PEND && d_vld) begin
        pending[d_idx] <= dv && (rdata.deadline <= now_ms);
        if (dv && rdata.deadline <= now_ms) pend_cnt <= pend_cnt + CW'(1);
      end
      if (state == S_PEND && scan_end) scan_idx <= '0;

      // Earliest deadline, newest first on ties
      if (state == S_SEL && d_vld && pending[d_idx] && better) begin
        best_vld <= 1'b1;
        best_idx <= d_idx;
        best_ord <= r_ord;
        best_ent <= rdata;
      end

      if (state == S_FIRE) begin
        pending[best_idx] <= 1'b0;
        pend_cnt          <= pend_cnt - CW'(1);
        fire_cnt          <= fire_cnt + FW'(1);
        fire_last         <= (pend_cnt == CW'(1)) || (fire_cnt == FW'(MAX_RESULTS - 1));
      end

      if (state == S_EMIT && out_load) begin
        scan_idx <= '0;
        best_vld <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
    if (out_load) begin
      if (state == S_EMIT) begin
        o_status <= ST_FIRED;
        o_id     <= best_ent.id;
        o_owner  <= best_ent.owner;
        o_method <= best_ent.method;
        o_last   <= fire_last;
      end else begin
        o_status <= resp_status;
        o_id     <= (resp_status == ST_PUSHED) ? push_id : 16'd0;
        o_owner  <= 16'd0;
        o_method <= 8'd0;
        o_last   <= 1'b1;
      end
    end
  end

endmodule

/* hdl/ptt_checker.sv */
// Port-level checks for the periodic timer table, bound to the top level.
module ptt_checker
  import ptt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [15:0] out_owner,
  input logic       out_last
);

  // A held response stays until its transfer
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("response dropped while stalled");

  // One command at a time: a transfer closes the command port
  a_cmd_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command port open right after a transfer");

  // Only fire results may be followed by more results
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_FIRED |-> out_last)
    else $error("non-fire response without last");

  // Owner only on fire results
  a_owner: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_FIRED |-> out_owner == 16'd0)
    else $error("owner on non-fire response");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (cmd.valid),
  .in_ready   (cmd.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .out_status (rsp.status),
  .out_owner  (rsp.result_owner),
  .out_last   (rsp.last)
);

/* tb/tb_periodic_timer_table.sv */
// Self-checking testbench for the periodic timer table: directed and random commands, predicted responses.
`timescale 1ns / 100ps

module tb_periodic_timer_table;
  import ptt_pkg::*;

  localparam int DEPTH        = 16;
  localparam int MS_PER_S     = 1000;
  localparam int STALL_LIMIT  = 6000;
  localparam int SETTLE_CYC   = 60;
  localparam logic [2:0] KIND_RSVD_A = 3'd6;
  localparam logic [2:0] KIND_RSVD_B = 3'd7;
  localparam logic [47:0] MS_MAX = {48{1'b1}};

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] owner;
    logic [7:0]  method;
    logic        match_method;
    logic [31:0] interval_ms;
    logic        repeat_req;
    logic [31:0] schedule_s;
    logic [15:0] timer_id;
  } cmd_item_t;

  typedef struct {
    status_t     status;
    logic [15:0] id;
    logic [15:0] owner;
    logic [7:0]  method;
    logic        last;
  } rsp_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ptt_cmd_if cmd ();
  ptt_rsp_if rsp ();

  periodic_timer_table u_dut (
    .clk(clk), .rst(rst), .cmd(cmd.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Shadow timer store
  logic [15:0] m_period, m_countdown, m_next_id, m_count;
  logic [47:0] m_now;
  logic        m_valid [DEPTH];
  logic [47:0] m_deadline [DEPTH];
  logic [31:0] m_interval [DEPTH];
  logic        m_rpt [DEPTH];
  logic [15:0] m_owner [DEPTH];
  logic [7:0]  m_method [DEPTH];
  logic [15:0] m_id [DEPTH];
  logic [15:0] m_rank [DEPTH];

  rsp_item_t due_rsps [$];
  int  mismatches = 0;
  bit  failed = 1'b0;
  bit  no_idle = 1'b0;
  int  hold_cnt = 0;

  function automatic logic [47:0] deadline_add(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[48] ? MS_MAX : s[47:0];
  endfunction

  function automatic void expect_rsp(status_t st, logic [15:0] id, logic [15:0] ow,
                                     logic [7:0] me, logic la);
    rsp_item_t r;
    r.status = st; r.id = id; r.owner = ow; r.method = me; r.last = la;
    due_rsps.push_back(r);
  endfunction

  function automatic void drop_timer(int i);
    m_valid[i] = 1'b0;
    for (int j = 0; j < DEPTH; j++)
      if (m_valid[j] && m_rank[j] > m_rank[i]) m_rank[j]--;
    m_count--;
  endfunction

  function automatic void promote_timer(int i);
    for (int j = 0; j < DEPTH; j++)
      if (j != i && m_valid[j] && m_rank[j] > m_rank[i]) m_rank[j]--;
    m_rank[i] = m_count - 16'd1;
  endfunction

  function automatic int slot_of_id(logic [15:0] id);
    for (int i = 0; i < DEPTH; i++)
      if (m_valid[i] && m_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void store_timer(logic [47:0] dl, logic [31:0] iv, logic rp,
                                      logic [15:0] ow, logic [7:0] me);
    for (int i = 0; i < DEPTH; i++)
      if (!m_valid[i]) begin
        m_valid[i] = 1'b1; m_deadline[i] = dl; m_interval[i] = iv; m_rpt[i] = rp;
        m_owner[i] = ow; m_method[i] = me; m_id[i] = m_next_id; m_rank[i] = m_count;
        m_count++; m_next_id++;
        expect_rsp(ST_PUSHED, m_id[i], '0, '0, 1'b1);
        return;
      end
    expect_rsp(ST_FULL, '0, '0, '0, 1'b1);
  endfunction

  // Schedule check: fire due timers in deadline order, newest first on ties
  function automatic void fire_due();
    bit pend [DEPTH];
    int n, best;
    n = 0;
    for (int i = 0; i < DEPTH; i++) pend[i] = m_valid[i] && m_deadline[i] <= m_now;
    while (n < MAX_RESULTS) begin
      best = -1;
      for (int i = 0; i < DEPTH; i++)
        if (pend[i] && (best < 0 || m_deadline[i] < m_deadline[best] ||
            (m_deadline[i] == m_deadline[best] && m_rank[i] > m_rank[best])))
          best = i;
      if (best < 0) break;
      pend[best] = 1'b0;
      expect_rsp(ST_FIRED, m_id[best], m_owner[best], m_method[best], 1'b0);
      n++;
      if (m_rpt[best]) begin
        m_deadline[best] = deadline_add(m_now, m_interval[best]);
        promote_timer(best);
      end else begin
        drop_timer(best);
      end
    end
    if (n > 0) due_rsps[$].last = 1'b1;
  endfunction

  function automatic void predict_cmd(cmd_item_t c);
    int i;
    bit hit;
    case (c.kind)
      K_TICK: begin
        m_now = m_now + 48'd1;
        if (m_countdown <= 16'd1) begin
          m_countdown = m_period;
          fire_due();
        end else begin
          m_countdown--;
        end
      end
      K_PUSH_REL:
        store_timer(deadline_add(m_now, c.interval_ms), c.interval_ms, c.repeat_req,
                    c.owner, c.method);
      K_PUSH_ABS:
        store_timer(48'(64'(c.schedule_s) * MS_PER_S), '0, 1'b0, c.owner, c.method);
      K_CANCEL_ID: begin
        i = slot_of_id(c.timer_id);
        if (i >= 0) begin
          drop_timer(i);
          expect_rsp(ST_CANCELLED, '0, '0, '0, 1'b1);
        end else expect_rsp(ST_NOT_FOUND, '0, '0, '0, 1'b1);
      end
      K_CANCEL_OWNER: begin
        if (c.owner == '0) expect_rsp(ST_OWNER_NULL, '0, '0, '0, 1'b1);
        else begin
          hit = 1'b0;
          for (int j = 0; j < DEPTH; j++)
            if (m_valid[j] && m_owner[j] == c.owner &&
                (!c.match_method || m_method[j] == c.method)) begin
              drop_timer(j);
              hit = 1'b1;
            end
          expect_rsp(hit ? ST_CANCELLED : ST_NOT_FOUND, '0, '0, '0, 1'b1);
        end
      end
      K_SET_INTERVAL: begin
        i = slot_of_id(c.timer_id);
        if (i >= 0) begin
          m_interval[i] = c.interval_ms;
          m_deadline[i] = deadline_add(m_now, c.interval_ms);
          promote_timer(i);
          expect_rsp(ST_INTERVAL_SET, '0, '0, '0, 1'b1);
        end else expect_rsp(ST_NOT_FOUND, '0, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // Command driver: random gaps before each item unless no_idle is set, prediction at the transfer
  task automatic send_cmd(cmd_item_t c);
    while (!no_idle && $urandom_range(0, 99) < 37) begin
      cmd.valid = 1'b0;
      @(negedge clk);
    end
    cmd.kind = c.kind; cmd.owner = c.owner; cmd.method = c.method;
    cmd.match_method = c.match_method; cmd.interval_ms = c.interval_ms;
    cmd.repeat_req = c.repeat_req; cmd.schedule_s = c.schedule_s;
    cmd.timer_id = c.timer_id; cmd.valid = 1'b1;
    do @(posedge clk); while (!cmd.ready);
    predict_cmd(c);
    @(negedge clk);
  endtask

  function automatic cmd_item_t mk(logic [2:0] k, logic [15:0] ow = 16'd1,
                                   logic [7:0] me = 8'd0, logic [31:0] iv = 32'd0,
                                   logic rp = 1'b0, logic [31:0] sc = 32'd0,
                                   logic [15:0] id = 16'd0, logic mm = 1'b0);
    cmd_item_t c;
    c.kind = k; c.owner = ow; c.method = me; c.interval_ms = iv; c.repeat_req = rp;
    c.schedule_s = sc; c.timer_id = id; c.match_method = mm;
    return c;
  endfunction

  task automatic ticks(int n);
    repeat (n) send_cmd(mk(K_TICK));
  endtask

  task automatic wait_idle();
    cmd.valid = 1'b0;
    while (due_rsps.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // APB write: setup then access, both started at the falling edge
  task automatic write_period(logic [31:0] v);
    wait_idle();
    paddr = {REG_CHECK_PERIOD, 2'b00}; pwdata = v; pwrite = 1'b1;
    psel = 1'b1; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (v[15:0] != '0) begin
      m_period = v[15:0];
      m_countdown = v[15:0];
    end
  endtask

  // Response receiver: random stalls, or a forced hold-off
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      rsp.ready = 1'b0;
      hold_cnt = hold_cnt - 1;
    end else begin
      rsp.ready = no_idle || ($urandom_range(0, 99) >= 37);
    end
  end

  // Response checker
  always @(posedge clk) begin
    rsp_item_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (due_rsps.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected response status=%0d", rsp.status);
      end else begin
        e = due_rsps.pop_front();
        if (rsp.status !== e.status || rsp.result_id !== e.id ||
            rsp.result_owner !== e.owner || rsp.result_method !== e.method ||
            rsp.last !== e.last) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d id=%h ow=%h me=%h last=%b, got st=%0d id=%h ow=%h me=%h last=%b",
                     e.status, e.id, e.owner, e.method, e.last, rsp.status, rsp.result_id,
                     rsp.result_owner, rsp.result_method, rsp.last);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  int quiet = 0;
  always @(posedge clk) begin
    if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("FAIL periodic_timer_table");
      $finish;
    end
  end

  // Directed: relative and absolute pushes at field extremes, firing order
  task automatic test_push_fire();
    write_period(32'd0);
    write_period(32'd4);
    send_cmd(mk(K_PUSH_REL, 16'hFFFF, 8'hFF, 32'd0, 1'b0));
    send_cmd(mk(K_PUSH_REL, 16'd2, 8'd1, 32'd1, 1'b1));
    send_cmd(mk(K_PUSH_REL, 16'd3, 8'd2, 32'hFFFF_FFFF, 1'b1));
    send_cmd(mk(K_PUSH_ABS, 16'd4, 8'd3, 32'd0, 1'b0, 32'd0));
    send_cmd(mk(K_PUSH_ABS, 16'd5, 8'd4, 32'd0, 1'b0, 32'hFFFF_FFFF));
    send_cmd(mk(K_PUSH_ABS, 16'd6, 8'd5, 32'd0, 1'b1, 32'd0));
    ticks(9);
  endtask

  // Directed: cancel by id and owner, owner zero, set interval, reserved kinds
  task automatic test_cancel_rearm();
    send_cmd(mk(K_CANCEL_ID, 16'd0, 8'd0, 32'd0, 1'b0, 32'd0, 16'd2));
    send_cmd(mk(K_CANCEL_ID, 16'd0, 8'd0, 32'd0, 1'b0, 32'd0, 16'hFFFF));
    send_cmd(mk(K_SET_INTERVAL, 16'd0, 8'd0, 32'd2, 1'b0, 32'd0, 16'd1));
    send_cmd(mk(K_SET_INTERVAL, 16'd0, 8'd0, 32'hFFFF_FFFF, 1'b0, 32'd0, 16'hFFFF));
    send_cmd(mk(K_CANCEL_OWNER, 16'd0));
    send_cmd(mk(K_CANCEL_OWNER, 16'd5, 8'd9, 32'd0, 1'b0, 32'd0, 16'd0, 1'b1));
    send_cmd(mk(K_CANCEL_OWNER, 16'd5, 8'd4, 32'd0, 1'b0, 32'd0, 16'd0, 1'b1));
    send_cmd(mk(KIND_RSVD_A));
    send_cmd(mk(KIND_RSVD_B));
    ticks(4);
    send_cmd(mk(K_CANCEL_OWNER, 16'd2));
    send_cmd(mk(K_CANCEL_OWNER, 16'd3));
  endtask

  // Directed: fill the table, overflow it, fire sixteen at once
  task automatic test_full_table();
    write_period(32'd1);
    for (int i = 0; i < DEPTH + 1; i++)
      send_cmd(mk(K_PUSH_REL, 16'hABCD, 8'(i), 32'd0, 1'b1));
    ticks(2);
    send_cmd(mk(K_CANCEL_OWNER, 16'hABCD));
  endtask

  // Receiver holds off while commands keep coming
  task automatic test_backpressure();
    write_period(32'd2);
    hold_cnt = 400;
    for (int i = 0; i < 12; i++)
      send_cmd(mk(i[0] ? K_TICK : K_PUSH_REL, 16'd7, 8'(i), 32'(i % 3), 1'b1));
    send_cmd(mk(K_CANCEL_OWNER, 16'd7));
  endtask

  function automatic cmd_item_t random_cmd();
    cmd_item_t c;
    int pick, live [$];
    c.owner = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    c.method = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    c.match_method = 1'($urandom);
    c.repeat_req = 1'($urandom);
    c.interval_ms = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 30));
    c.schedule_s = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 1));
    for (int i = 0; i < DEPTH; i++) if (m_valid[i]) live.push_back(m_id[i]);
    c.timer_id = (live.size() > 0 && $urandom_range(0, 3) != 0)
                 ? 16'(live[$urandom_range(0, live.size() - 1)]) : 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45)      c.kind = K_TICK;
    else if (pick < 65) c.kind = K_PUSH_REL;
    else if (pick < 72) c.kind = K_PUSH_ABS;
    else if (pick < 81) c.kind = K_CANCEL_ID;
    else if (pick < 88) c.kind = K_CANCEL_OWNER;
    else if (pick < 97) c.kind = K_SET_INTERVAL;
    else                c.kind = $urandom_range(0, 1) ? KIND_RSVD_A : KIND_RSVD_B;
    return c;
  endfunction

  // Random phases over several check periods
  task automatic test_random();
    logic [31:0] periods [5] = '{32'd1, 32'd3, 32'd7, 32'd19, 32'd2};
    for (int p = 0; p < 5; p++) begin
      write_period(periods[p]);
      no_idle = (p == 2);
      repeat (58) send_cmd(random_cmd());
    end
    no_idle = 1'b0;
    // longest period: commands only, then back to a short one
    write_period(32'h0000_FFFF);
    repeat (10) send_cmd(random_cmd());
    write_period(32'hFFFF_0005);
    repeat (20) send_cmd(random_cmd());
  endtask

  initial begin
    cmd.valid = 1'b0; cmd.kind = K_TICK; cmd.owner = '0; cmd.method = '0;
    cmd.match_method = 1'b0; cmd.interval_ms = '0; cmd.repeat_req = 1'b0;
    cmd.schedule_s = '0; cmd.timer_id = '0;
    rsp.ready = 1'b0;
    m_period = CHECK_PERIOD_RST; m_countdown = CHECK_PERIOD_RST;
    m_now = '0; m_next_id = '0; m_count = '0;
    for (int i = 0; i < DEPTH; i++) m_valid[i] = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_push_fire();
    test_cancel_rearm();
    test_full_table();
    test_backpressure();
    test_random();
    wait_idle();
    if (!failed && due_rsps.size() == 0) begin
      $display("PASS periodic_timer_table");
    end else begin
      $display("FAIL periodic_timer_table");
    end
    $finish;
  end

endmodule
